### rtl/phba_pkg.sv
// shared constants, record codes and lane interface structs for the per-host
// byte accounting unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package phba_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int LEN_W   = 16;
    localparam int TOTAL_W = 32;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 120;

    localparam logic [TOTAL_W-1:0] ALARM_RESET = 32'd1000000;

    localparam logic ACT_ACCOUNT = 1'b0;
    localparam logic ACT_REPORT  = 1'b1;

    typedef enum logic [1:0] {
        REC_ACK   = 2'd0,
        REC_SRC   = 2'd1,
        REC_DST   = 2'd2,
        REC_EMPTY = 2'd3
    } rec_kind_t;

    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } host_key_t;

    typedef struct packed {
        logic             start;
        logic             clear;
        host_key_t        key;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] rd_addr;
    } lane_cmd_t;

    typedef struct packed {
        logic             done;
        logic             dropped;
        logic [CNT_W-1:0] used;
    } lane_stat_t;

    typedef struct packed {
        host_key_t          key;
        logic [TOTAL_W-1:0] total;
    } lane_entry_t;

    typedef enum logic {
        L_IDLE,
        L_SEARCH
    } lane_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_WAIT,
        T_ACK,
        T_READ,
        T_EMIT
    } top_state_t;

endpackage

`default_nettype wire

### rtl/per_host_byte_accounting_unit.sv
// per-host byte accounting top level: two lanes (source and destination
// tables) plus the merging stage and result register; depends on phba_pkg, phba_lane
//
//  channel | dir | handshake            | contents
//  s_*     | in  | s_tvalid / s_tready  | tuser action, tdata packet keys and length
//  m_*     | out | m_tvalid / m_tready  | tuser record kind, tdata entry, tlast
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_data alarm threshold
//
// account: the accept starts both lanes, which search their tables in parallel;
// the sequencer waits in T_WAIT until both lanes report done, then loads the
// acknowledge into the result register
// report: after the accept, each listed entry is read from the registered table
// (T_READ) and then emitted (T_EMIT); an empty report goes to the marker directly
// reset clears both fill counts and the threshold goes to 1000000
// a stalled result register holds the sequencer; s_tready is high only when idle
`timescale 1ns / 1ps
`default_nettype none

module per_host_byte_accounting_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // src_mac, src_ip, dst_mac, dst_ip, packet_len
    input  wire logic [phba_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // entry_mac, entry_ip, byte_total, over_limit, src_dropped, dst_dropped, zero pad
    output logic [phba_pkg::OUT_DATA_W-1:0]         m_tdata,
    // record_kind
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [phba_pkg::TOTAL_W-1:0]       cfg_data
);
    import phba_pkg::*;

    top_state_t              state_reg, state_next;
    logic [TOTAL_W-1:0]      thr_reg;
    logic                    src_done_reg, src_done_next;
    logic                    dst_done_reg, dst_done_next;
    logic                    src_drop_reg, src_drop_next;
    logic                    dst_drop_reg, dst_drop_next;
    rec_kind_t               ack_kind_reg, ack_kind_next;
    logic                    sel_dst_reg, sel_dst_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]              m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    lane_cmd_t               src_cmd, dst_cmd;
    lane_stat_t              src_stat, dst_stat;
    lane_entry_t             src_entry, dst_entry;
    lane_entry_t             cur_entry;
    logic [CNT_W-1:0]        cur_used;
    logic [CNT_W-1:0]        idx_inc;
    logic                    out_free;
    logic                    over;

    phba_lane u_src_lane
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (src_cmd),
        .stat  (src_stat),
        .entry (src_entry)
    );

    phba_lane u_dst_lane
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dst_cmd),
        .stat  (dst_stat),
        .entry (dst_entry)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cur_entry = sel_dst_reg ? dst_entry : src_entry;
    assign cur_used  = sel_dst_reg ? dst_stat.used : src_stat.used;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign over      = (cur_entry.total >= thr_reg);

    always_comb
    begin
        state_next    = state_reg;
        src_done_next = src_done_reg;
        dst_done_next = dst_done_reg;
        src_drop_next = src_drop_reg;
        dst_drop_next = dst_drop_reg;
        ack_kind_next = ack_kind_reg;
        sel_dst_next  = sel_dst_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        src_cmd.start   = 1'b0;
        src_cmd.clear   = 1'b0;
        src_cmd.key.mac = s_tdata[47:0];
        src_cmd.key.ip  = s_tdata[79:48];
        src_cmd.len     = s_tdata[175:160];
        src_cmd.rd_addr = idx_reg[IDX_W-1:0];
        dst_cmd.start   = 1'b0;
        dst_cmd.clear   = 1'b0;
        dst_cmd.key.mac = s_tdata[127:80];
        dst_cmd.key.ip  = s_tdata[159:128];
        dst_cmd.len     = s_tdata[175:160];
        dst_cmd.rd_addr = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            T_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_ACCOUNT)
                    begin
                        src_cmd.start = 1'b1;
                        dst_cmd.start = 1'b1;
                        src_done_next = 1'b0;
                        dst_done_next = 1'b0;
                        state_next    = T_WAIT;
                    end
                    else if (src_stat.used == '0 && dst_stat.used == '0)
                    begin
                        ack_kind_next = REC_EMPTY;
                        src_drop_next = 1'b0;
                        dst_drop_next = 1'b0;
                        state_next    = T_ACK;
                    end
                    else
                    begin
                        sel_dst_next = (src_stat.used == '0);
                        idx_next     = '0;
                        state_next   = T_READ;
                    end
                end
            end
            T_WAIT:
            begin
                src_done_next = src_done_reg || src_stat.done;
                dst_done_next = dst_done_reg || dst_stat.done;
                if (src_stat.done)
                begin
                    src_drop_next = src_stat.dropped;
                end
                if (dst_stat.done)
                begin
                    dst_drop_next = dst_stat.dropped;
                end
                if (src_done_next && dst_done_next)
                begin
                    ack_kind_next = REC_ACK;
                    state_next    = T_ACK;
                end
            end
            T_ACK:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ack_kind_reg;
                    m_tdata_next  = {5'b0, dst_drop_reg, src_drop_reg, 113'b0};
                    m_tlast_next  = 1'b1;
                    state_next    = T_IDLE;
                end
            end
            T_READ:
            begin
                state_next = T_EMIT;
            end
            T_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = sel_dst_reg ? REC_DST : REC_SRC;
                    m_tdata_next  = {5'b0, 2'b0, over, cur_entry.total,
                                     cur_entry.key.ip, cur_entry.key.mac};
                    if (idx_inc < cur_used)
                    begin
                        idx_next     = idx_inc;
                        m_tlast_next = 1'b0;
                        state_next   = T_READ;
                    end
                    else if (!sel_dst_reg && dst_stat.used != '0)
                    begin
                        sel_dst_next = 1'b1;
                        idx_next     = '0;
                        m_tlast_next = 1'b0;
                        state_next   = T_READ;
                    end
                    else
                    begin
                        m_tlast_next  = 1'b1;
                        src_cmd.clear = 1'b1;
                        dst_cmd.clear = 1'b1;
                        state_next    = T_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            thr_reg      <= ALARM_RESET;
            src_done_reg <= 1'b0;
            dst_done_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            src_done_reg <= src_done_next;
            dst_done_reg <= dst_done_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_drop_reg <= src_drop_next;
        dst_drop_reg <= dst_drop_next;
        ack_kind_reg <= ack_kind_next;
        sel_dst_reg  <= sel_dst_next;
        idx_reg      <= idx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == REC_ACK || m_tuser == REC_EMPTY)) |-> m_tlast)
        else $error("single-record result not marked last");

    a_entry_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == REC_SRC || m_tuser == REC_DST)) |->
        (m_tdata[114:113] == 2'b00))
        else $error("entry record carries drop flags");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE && s_tvalid && s_tuser == ACT_REPORT &&
         src_stat.used == '0 && dst_stat.used == '0) |=> (state_reg == T_ACK))
        else $error("empty report did not go to marker");

    a_lanes_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_WAIT && src_done_reg && dst_done_reg) |-> 1'b0)
        else $error("sequencer stuck after both lanes finished");

endmodule

`default_nettype wire

### rtl/phba_lane.sv
// one accounting lane: key/total table in memory, linear key search,
// saturating accumulate or append; depends on phba_pkg
`timescale 1ns / 1ps
`default_nettype none

module phba_lane
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire phba_pkg::lane_cmd_t  cmd,
    output phba_pkg::lane_stat_t      stat,
    output phba_pkg::lane_entry_t     entry
);
    import phba_pkg::*;

    host_key_t          key_mem   [TABLE_DEPTH];
    logic [TOTAL_W-1:0] total_mem [TABLE_DEPTH];

    lane_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    host_key_t          key_reg, key_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               drop_reg, drop_next;
    logic               done_reg, done_next;
    host_key_t          rd_key_reg;
    logic [TOTAL_W-1:0] rd_total_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [TOTAL_W-1:0] wr_total;
    logic [IDX_W-1:0]   rd_idx;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat_total;

    assign sum       = {1'b0, rd_total_reg} + {{(TOTAL_W + 1 - LEN_W){1'b0}}, len_reg};
    assign sat_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        used_next     = used_reg;
        key_next      = key_reg;
        len_next      = len_reg;
        drop_next     = drop_reg;
        done_next     = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = pend_idx_reg;
        wr_total      = sat_total;
        rd_idx        = cmd.rd_addr;
        unique case (state_reg)
            L_IDLE:
            begin
                if (cmd.start)
                begin
                    key_next   = cmd.key;
                    len_next   = cmd.len;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    drop_next  = 1'b0;
                    state_next = L_SEARCH;
                end
                else if (cmd.clear)
                begin
                    used_next = '0;
                end
            end
            L_SEARCH:
            begin
                rd_idx = scan_reg[IDX_W-1:0];
                if (pend_reg && (rd_key_reg == key_reg))
                begin
                    // hit: accumulate in place
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
                else if (scan_reg < used_reg)
                begin
                    scan_next     = scan_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    // miss: append or drop when full
                    if (used_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = used_reg[IDX_W-1:0];
                        wr_total  = {{(TOTAL_W - LEN_W){1'b0}}, len_reg};
                        used_next = used_reg + CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            used_reg  <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            used_reg  <= used_next;
            drop_reg  <= drop_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        len_reg      <= len_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx]   <= key_reg;
            total_mem[wr_idx] <= wr_total;
        end
        rd_key_reg   <= key_mem[rd_idx];
        rd_total_reg <= total_mem[rd_idx];
    end

    assign stat.done    = done_reg;
    assign stat.dropped = drop_reg;
    assign stat.used    = used_reg;
    assign entry.key    = rd_key_reg;
    assign entry.total  = rd_total_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("lane fill count beyond table depth");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && drop_reg) |-> (used_reg == CNT_W'(TABLE_DEPTH)))
        else $error("key dropped while table had room");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == L_IDLE))
        else $error("lane started while searching");

endmodule

`default_nettype wire

### test/host_total_checker.sv
// byte accounting checker: keeps its own source and destination host tables,
// predicts every record from the packet and report transfers and compares the
// result stream field by field; depends on phba_pkg
`timescale 1ns / 1ps

module host_total_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [phba_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [phba_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic [1:0]                      m_tuser,
    input  wire logic                            m_tlast,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [phba_pkg::TOTAL_W-1:0]    cfg_data,
    output int                                   pending,
    output int                                   fail_count
);
    import phba_pkg::*;

    localparam int SIDE_SRC = 0;
    localparam int SIDE_DST = 1;

    typedef struct packed {
        rec_kind_t          kind;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
        logic [TOTAL_W-1:0] total;
        logic               over;
        logic               src_drop;
        logic               dst_drop;
        logic               last;
    } host_record_t;

    host_key_t          host_key   [2][TABLE_DEPTH];
    logic [TOTAL_W-1:0] host_total [2][TABLE_DEPTH];
    int                 host_used  [2];
    logic [TOTAL_W-1:0] alarm_level;
    host_record_t       expected_records [$];
    int                 mismatches = 0;

    function automatic void queue_record(input host_record_t rec);
        expected_records.insert(expected_records.size(), rec);
    endfunction

    // returns 1 when a new key finds its table full
    function automatic logic account_host(input int side, input host_key_t key,
                                          input logic [LEN_W-1:0] len);
        int          i;
        logic        found;
        logic [32:0] sum;
        found = 1'b0;
        account_host = 1'b0;
        for (i = 0; i < host_used[side]; i++)
        begin
            if (!found && host_key[side][i] == key)
            begin
                sum = {1'b0, host_total[side][i]} + len;
                host_total[side][i] = sum[32] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (host_used[side] >= TABLE_DEPTH)
                account_host = 1'b1;
            else
            begin
                host_key[side][host_used[side]] = key;
                host_total[side][host_used[side]] = {{(TOTAL_W-LEN_W){1'b0}}, len};
                host_used[side]++;
            end
        end
    endfunction

    function automatic void list_and_clear();
        int           side;
        int           i;
        int           count;
        int           listed;
        host_record_t rec;
        count = host_used[SIDE_SRC] + host_used[SIDE_DST];
        listed = 0;
        for (side = SIDE_SRC; side <= SIDE_DST; side++)
        begin
            for (i = 0; i < host_used[side]; i++)
            begin
                rec = '0;
                if (side == SIDE_SRC)
                    rec.kind = REC_SRC;
                else
                    rec.kind = REC_DST;
                rec.mac = host_key[side][i].mac;
                rec.ip = host_key[side][i].ip;
                rec.total = host_total[side][i];
                rec.over = (host_total[side][i] >= alarm_level);
                listed++;
                rec.last = (listed == count);
                queue_record(rec);
            end
        end
        if (count == 0)
        begin
            rec = '0;
            rec.kind = REC_EMPTY;
            rec.last = 1'b1;
            queue_record(rec);
        end
        host_used[SIDE_SRC] = 0;
        host_used[SIDE_DST] = 0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        host_record_t rec;
        if (!rst_n)
        begin
            alarm_level = ALARM_RESET;
            host_used[SIDE_SRC] = 0;
            host_used[SIDE_DST] = 0;
            expected_records.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                alarm_level = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("result transfer of kind %0d with nothing expected", m_tuser);
                    mismatches++;
                end
                else
                begin
                    rec = expected_records.pop_front();
                    check_field("record_kind", rec.kind, m_tuser);
                    check_field("entry_mac", rec.mac, m_tdata[47:0]);
                    check_field("entry_ip", rec.ip, m_tdata[79:48]);
                    check_field("byte_total", rec.total, m_tdata[111:80]);
                    check_field("over_limit", rec.over, m_tdata[112]);
                    check_field("src_dropped", rec.src_drop, m_tdata[113]);
                    check_field("dst_dropped", rec.dst_drop, m_tdata[114]);
                    check_field("tdata_pad", 64'd0, m_tdata[OUT_DATA_W-1:115]);
                    check_field("last", rec.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_ACCOUNT)
                begin
                    rec = '0;
                    rec.kind = REC_ACK;
                    rec.src_drop = account_host(SIDE_SRC, {s_tdata[47:0], s_tdata[79:48]},
                                                s_tdata[175:160]);
                    rec.dst_drop = account_host(SIDE_DST, {s_tdata[127:80], s_tdata[159:128]},
                                                s_tdata[175:160]);
                    rec.last = 1'b1;
                    queue_record(rec);
                end
                else
                    list_and_clear();
            end
            pending <= expected_records.size();
            fail_count <= mismatches;
        end
    end

endmodule

### test/tb_per_host_byte_accounting_unit.sv
// testbench top for the per-host byte accounting unit: directed and random
// packet/report traffic, threshold writes, back pressure and the verdict;
// depends on phba_pkg, per_host_byte_accounting_unit and host_total_checker
`timescale 1ns / 1ps

module tb_per_host_byte_accounting_unit;
    import phba_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int POOL_SIZE      = 64;
    localparam int FLOOD_ITEMS    = 36;
    localparam int PHASE_ITEMS    = 68;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam int FLOOD_SRC  = 0;
    localparam int FLOOD_DST  = 1;
    localparam int FLOOD_BOTH = 2;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = ACT_ACCOUNT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TOTAL_W-1:0]    cfg_data  = '0;

    int   pending;
    int   fail_count;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    logic hold_go      = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;
    int   stall_cycles = 0;

    logic [MAC_W-1:0] pool_mac [POOL_SIZE];
    logic [IP_W-1:0]  pool_ip  [POOL_SIZE];

    per_host_byte_accounting_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    host_total_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver: random back pressure plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [LEN_W-1:0] rand_len();
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0: rand_len = '0;
            1: rand_len = '1;
            default:
            begin
                r = $urandom;
                rand_len = r[LEN_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_data();
        logic [191:0] wide;
        int           i;
        for (i = 0; i < 192; i += 32)
            wide[i +: 32] = $urandom;
        rand_data = wide[IN_DATA_W-1:0];
    endfunction

    task automatic offer(input logic act, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_packet(input int src, input int dst, input logic [LEN_W-1:0] len);
        offer(ACT_ACCOUNT, {len, pool_ip[dst], pool_mac[dst], pool_ip[src], pool_mac[src]});
    endtask

    task automatic send_report();
        offer(ACT_REPORT, rand_data());
    endtask

    // stop offering until every predicted record has been seen
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TOTAL_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int flood, input logic with_hold);
        int sent;
        int n;
        int p;
        int base;
        int i;
        // opening window overruns at least one table
        for (i = 0; i < FLOOD_ITEMS; i++)
        begin
            if (with_hold && i == 10)
                hold_go <= 1'b1;
            case (flood)
                FLOOD_SRC: send_packet(i, $urandom_range(0, 3), rand_len());
                FLOOD_DST: send_packet($urandom_range(0, 3), i, rand_len());
                default:   send_packet(i, POOL_SIZE - 1 - i, rand_len());
            endcase
        end
        send_report();
        settle();
        sent = FLOOD_ITEMS + 1;
        while (sent < PHASE_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    offer($urandom_range(0, 1) ? ACT_REPORT : ACT_ACCOUNT, rand_data());
                    sent++;
                end
                1:
                begin
                    send_report();
                    sent++;
                end
                default:
                begin
                    n = $urandom_range(1, 12);
                    p = $urandom_range(1, 8);
                    base = $urandom_range(0, POOL_SIZE - 8);
                    for (i = 0; i < n; i++)
                        send_packet(base + $urandom_range(0, p - 1),
                                    base + $urandom_range(0, p - 1), rand_len());
                    send_report();
                    sent += n + 1;
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] r64;
        int          i;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            r64 = {$urandom, $urandom};
            pool_mac[i] = r64[MAC_W-1:0];
            pool_ip[i] = $urandom;
        end
        pool_mac[0] = '0;
        pool_ip[0] = '0;
        pool_mac[1] = '1;
        pool_ip[1] = '1;
        // keys that differ in only one half
        pool_mac[3] = pool_mac[2];
        pool_ip[5] = pool_ip[4];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 51;

        // empty tables, extreme keys, half-matching keys, accumulate
        send_report();
        send_packet(0, 0, '0);
        send_packet(1, 1, '1);
        send_packet(2, 4, 16'd1);
        send_packet(3, 5, 16'd2);
        send_packet(1, 0, '1);
        send_report();

        // totals just at and just below the threshold
        write_threshold(32'd131070);
        send_packet(6, 6, 16'hFFFF);
        send_packet(6, 6, 16'hFFFF);
        send_packet(7, 7, 16'hFFFF);
        send_packet(7, 7, 16'hFFFE);
        send_report();

        write_threshold('0);
        send_packet(0, 1, '0);
        send_report();

        write_threshold($urandom_range(0, 300000));
        random_phase(FLOOD_SRC, 1'b1);

        tx_idle_pct = 51;
        rx_idle_pct = 27;
        write_threshold($urandom);
        random_phase(FLOOD_DST, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_threshold($urandom_range(0, 200000));
        random_phase(FLOOD_BOTH, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
